/* hdl/uart_rx_tx_ring_buffers_macros.svh */
// assertion helpers used by the top-level module
`ifndef UART_RX_TX_RING_BUFFERS_MACROS_SVH
`define UART_RX_TX_RING_BUFFERS_MACROS_SVH

// same-cycle implication
`define URTB_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication
`define URTB_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

/* hdl/urtb_pkg.sv */
package urtb_pkg;

   localparam int RX_DEPTH = 16;
   localparam int TX_DEPTH = 16;

   localparam int RX_PTR_W = $clog2(RX_DEPTH);
   localparam int RX_CNT_W = RX_PTR_W + 1;
   localparam int TX_PTR_W = $clog2(TX_DEPTH);
   localparam int TX_SUM_W = TX_PTR_W + 1;

   localparam int BYTE_W  = 8;
   localparam int KIND_W  = 3;
   localparam int COUNT_W = 4;

   localparam logic [BYTE_W-1:0] BYTE_LF = 8'h0A;
   localparam logic [BYTE_W-1:0] BYTE_CR = 8'h0D;

   typedef enum logic [KIND_W-1:0] {
      KIND_RX_BYTE    = 3'd0,
      KIND_HOST_READ  = 3'd1,
      KIND_HOST_WRITE = 3'd2,
      KIND_TX_DONE    = 3'd3,
      KIND_PEEK       = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_PUSH_LF
   } state_type;

   typedef struct packed {
      logic capture;
      logic execute;
      logic push_lf;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic lf_pending;
   } sts_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  read_byte;
      logic [COUNT_W-1:0] rx_count;
      logic [BYTE_W-1:0]  next_byte;
      logic [BYTE_W-1:0]  latest_byte;
      logic               rx_dropped;
      logic               send_valid;
      logic [BYTE_W-1:0]  send_byte;
      logic               write_ok;
      logic               tx_busy;
   } rsp_data_type;

endpackage

/* hdl/urtb_ifs.sv */
interface urtb_req_if import urtb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [BYTE_W-1:0] rx_line_byte;
   logic [BYTE_W-1:0] write_byte;

   modport source (output valid, kind, rx_line_byte, write_byte, input ready);
   modport sink (input valid, kind, rx_line_byte, write_byte, output ready);
endinterface

interface urtb_rsp_if import urtb_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [BYTE_W-1:0]  read_byte;
   logic [COUNT_W-1:0] rx_count;
   logic [BYTE_W-1:0]  next_byte;
   logic [BYTE_W-1:0]  latest_byte;
   logic               rx_dropped;
   logic               send_valid;
   logic [BYTE_W-1:0]  send_byte;
   logic               write_ok;
   logic               tx_busy;

   modport source (output valid, read_byte, rx_count, next_byte, latest_byte, rx_dropped,
                   send_valid, send_byte, write_ok, tx_busy, input ready);
   modport sink (input valid, read_byte, rx_count, next_byte, latest_byte, rx_dropped,
                 send_valid, send_byte, write_ok, tx_busy, output ready);
endinterface

interface urtb_csr_if;
   logic valid;
   logic ready;
   logic newline_expand;

   modport source (output valid, newline_expand, input ready);
   modport sink (input valid, newline_expand, output ready);
endinterface

/* hdl/uart_rx_tx_ring_buffers.sv */
// Serial-port front end with a receive ring and a transmit ring, each keeping one slot
// empty. When an item is taken, its ring entries are read into registers; the update step
// then applies the pointer update and loads the result register. A new item is accepted
// only once the last is through, and an LF write that queues a CR first adds a step for
// the LF (the transmit store has one write port). The update step waits while the result
// register still holds an untaken result. The receive store needs no clearing pass:
// per-entry valid bits make unwritten entries read as zero. The newline_expand register
// is written through the csr channel, which is always ready.
`include "uart_rx_tx_ring_buffers_macros.svh"

module uart_rx_tx_ring_buffers import urtb_pkg::*; (
   input logic              clock,
   input logic              reset,
   urtb_req_if.sink         req_bus,
   urtb_rsp_if.source       rsp_bus,
   urtb_csr_if.sink         csr_bus
);

   cmd_type      ctl_cmd;
   sts_type      dp_sts;
   rsp_data_type rsp_data;
   logic         rsp_valid;

   urtb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .sts       (dp_sts),
      .cmd       (ctl_cmd)
   );

   urtb_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (ctl_cmd),
      .sts                (dp_sts),
      .req_kind           (req_bus.kind),
      .req_rx_line_byte   (req_bus.rx_line_byte),
      .req_write_byte     (req_bus.write_byte),
      .csr_write          (csr_bus.valid),
      .csr_newline_expand (csr_bus.newline_expand),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_bus.ready),
      .rsp_data           (rsp_data)
   );

   assign csr_bus.ready       = 1'b1;
   assign rsp_bus.valid       = rsp_valid;
   assign rsp_bus.read_byte   = rsp_data.read_byte;
   assign rsp_bus.rx_count    = rsp_data.rx_count;
   assign rsp_bus.next_byte   = rsp_data.next_byte;
   assign rsp_bus.latest_byte = rsp_data.latest_byte;
   assign rsp_bus.rx_dropped  = rsp_data.rx_dropped;
   assign rsp_bus.send_valid  = rsp_data.send_valid;
   assign rsp_bus.send_byte   = rsp_data.send_byte;
   assign rsp_bus.write_ok    = rsp_data.write_ok;
   assign rsp_bus.tx_busy     = rsp_data.tx_busy;

   // a result is never loaded over one still waiting
   `URTB_ASSERT_IMP(a_no_overwrite, clock, reset, ctl_cmd.execute, !rsp_bus.valid || rsp_bus.ready)
   // the block works on one item at a time
   `URTB_ASSERT_NXT(a_one_item, clock, reset, req_bus.valid && req_bus.ready, !req_bus.ready)
   // a queued write always leaves the transmitter busy
   `URTB_ASSERT_IMP(a_write_busy, clock, reset, rsp_bus.valid && rsp_bus.write_ok, rsp_bus.tx_busy)

endmodule

/* hdl/urtb_ctrl.sv */
module urtb_ctrl import urtb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // wait here until the result register can take the item
            if (sts.out_free) begin
               cmd.execute = 1'b1;
               state_in    = sts.lf_pending ? ST_PUSH_LF : ST_IDLE;
            end
         end
         ST_PUSH_LF: begin
            cmd.push_lf = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* hdl/urtb_dp.sv */
module urtb_dp import urtb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output sts_type           sts,
   input  logic [KIND_W-1:0] req_kind,
   input  logic [BYTE_W-1:0] req_rx_line_byte,
   input  logic [BYTE_W-1:0] req_write_byte,
   input  logic              csr_write,
   input  logic              csr_newline_expand,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_data_type      rsp_data
);

   // captured item
   logic [KIND_W-1:0] kind_ff;
   logic [BYTE_W-1:0] line_ff;
   logic [BYTE_W-1:0] wbyte_ff;

   // ring pointers and flags
   logic [RX_PTR_W-1:0] rx_wr_ff, rx_wr_in;
   logic [RX_PTR_W-1:0] rx_rd_ff, rx_rd_in;
   logic [TX_PTR_W-1:0] tx_send_ff, tx_send_in;
   logic [TX_PTR_W-1:0] tx_fill_ff, tx_fill_in;
   logic                busy_ff, busy_in;
   logic                expand_ff;

   // stores, valid bits and registered read data
   logic [BYTE_W-1:0]   rx_store_ff [RX_DEPTH];
   logic [RX_DEPTH-1:0] rx_vld_ff;
   logic [BYTE_W-1:0]   tx_store_ff [TX_DEPTH];
   logic [BYTE_W-1:0]   rx_next_ff;
   logic                rx_next_vld_ff;
   logic [BYTE_W-1:0]   rx_last_ff;
   logic                rx_last_vld_ff;
   logic [BYTE_W-1:0]   tx_head_ff;

   rsp_data_type rsp_data_ff;
   logic         rsp_valid_ff;

   logic [RX_PTR_W-1:0] rx_wr_nxt, rx_rd_nxt, rx_last_ptr, rx_held;
   logic [RX_CNT_W-1:0] rx_wrap_sum;
   logic [TX_PTR_W-1:0] tx_send_nxt, tx_fill_nxt, tx_held;
   logic [TX_SUM_W-1:0] tx_wrap_sum, tx_need, tx_total;
   logic                rx_full, rx_empty, need_two, tx_fits;
   logic [BYTE_W-1:0]   first_byte, rx_next_val, rx_last_val;
   logic                rx_we, tx_we;
   logic [BYTE_W-1:0]   tx_wdata;
   rsp_data_type        res;

   assign rx_wr_nxt   = (rx_wr_ff == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : rx_wr_ff + 1'b1;
   assign rx_rd_nxt   = (rx_rd_ff == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : rx_rd_ff + 1'b1;
   assign rx_last_ptr = (rx_wr_ff == '0) ? RX_PTR_W'(RX_DEPTH - 1) : rx_wr_ff - 1'b1;
   assign tx_send_nxt = (tx_send_ff == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : tx_send_ff + 1'b1;
   assign tx_fill_nxt = (tx_fill_ff == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : tx_fill_ff + 1'b1;

   assign rx_wrap_sum = RX_CNT_W'(rx_wr_ff) + RX_CNT_W'(RX_DEPTH) - RX_CNT_W'(rx_rd_ff);
   assign rx_held     = (rx_wr_ff >= rx_rd_ff) ? rx_wr_ff - rx_rd_ff
                                               : RX_PTR_W'(rx_wrap_sum);
   assign rx_full     = (rx_wr_nxt == rx_rd_ff);
   assign rx_empty    = (rx_wr_ff == rx_rd_ff);

   assign tx_wrap_sum = TX_SUM_W'(tx_fill_ff) + TX_SUM_W'(TX_DEPTH) - TX_SUM_W'(tx_send_ff);
   assign tx_held     = (tx_fill_ff >= tx_send_ff) ? tx_fill_ff - tx_send_ff
                                                   : TX_PTR_W'(tx_wrap_sum);
   assign need_two    = expand_ff && (wbyte_ff == BYTE_LF);
   assign tx_need     = need_two ? TX_SUM_W'(2) : TX_SUM_W'(1);
   assign tx_total    = TX_SUM_W'(tx_held) + tx_need;
   assign tx_fits     = (tx_total <= TX_SUM_W'(TX_DEPTH - 1));
   assign first_byte  = need_two ? BYTE_CR : wbyte_ff;

   // entries never written since reset read as zero
   assign rx_next_val = rx_next_vld_ff ? rx_next_ff : '0;
   assign rx_last_val = rx_last_vld_ff ? rx_last_ff : '0;

   assign sts.out_free   = !rsp_valid_ff || rsp_ready;
   assign sts.lf_pending = (kind_type'(kind_ff) == KIND_HOST_WRITE) && need_two && tx_fits;

   always_comb begin
      res        = '0;
      rx_wr_in   = rx_wr_ff;
      rx_rd_in   = rx_rd_ff;
      tx_send_in = tx_send_ff;
      tx_fill_in = tx_fill_ff;
      busy_in    = busy_ff;
      rx_we      = 1'b0;
      tx_we      = 1'b0;
      tx_wdata   = first_byte;
      if (cmd.execute) begin
         case (kind_type'(kind_ff))
            KIND_RX_BYTE: begin
               if (!rx_full) begin
                  rx_we    = 1'b1;
                  rx_wr_in = rx_wr_nxt;
               end else begin
                  res.rx_dropped = 1'b1;
               end
            end
            KIND_HOST_READ: begin
               if (!rx_empty) begin
                  res.rx_count  = COUNT_W'(rx_held);
                  res.read_byte = rx_next_val;
                  rx_rd_in      = rx_rd_nxt;
               end
            end
            KIND_HOST_WRITE: begin
               if (tx_fits) begin
                  tx_we        = 1'b1;
                  tx_fill_in   = tx_fill_nxt;
                  res.write_ok = 1'b1;
                  // idle transmitter takes the first byte straight away
                  if (!busy_ff) begin
                     res.send_valid = 1'b1;
                     res.send_byte  = first_byte;
                     tx_send_in     = tx_send_nxt;
                     busy_in        = 1'b1;
                  end
               end
            end
            KIND_TX_DONE: begin
               if (tx_send_ff != tx_fill_ff) begin
                  res.send_valid = 1'b1;
                  res.send_byte  = tx_head_ff;
                  tx_send_in     = tx_send_nxt;
               end else begin
                  busy_in = 1'b0;
               end
            end
            KIND_PEEK: begin
               res.rx_count    = COUNT_W'(rx_held);
               res.next_byte   = rx_next_val;
               res.latest_byte = rx_last_val;
            end
            default: begin
            end
         endcase
         res.tx_busy = busy_in;
      end
      // second slot of a cr/lf pair
      if (cmd.push_lf) begin
         tx_we      = 1'b1;
         tx_wdata   = BYTE_LF;
         tx_fill_in = tx_fill_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_wr_ff     <= '0;
         rx_rd_ff     <= '0;
         tx_send_ff   <= '0;
         tx_fill_ff   <= '0;
         busy_ff      <= 1'b0;
         expand_ff    <= 1'b0;
         rx_vld_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rx_wr_ff   <= rx_wr_in;
         rx_rd_ff   <= rx_rd_in;
         tx_send_ff <= tx_send_in;
         tx_fill_ff <= tx_fill_in;
         busy_ff    <= busy_in;
         if (csr_write) begin
            expand_ff <= csr_newline_expand;
         end
         if (rx_we) begin
            rx_vld_ff[rx_wr_ff] <= 1'b1;
         end
         if (cmd.execute) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff        <= req_kind;
         line_ff        <= req_rx_line_byte;
         wbyte_ff       <= req_write_byte;
         rx_next_ff     <= rx_store_ff[rx_rd_ff];
         rx_next_vld_ff <= rx_vld_ff[rx_rd_ff];
         rx_last_ff     <= rx_store_ff[rx_last_ptr];
         rx_last_vld_ff <= rx_vld_ff[rx_last_ptr];
         tx_head_ff     <= tx_store_ff[tx_send_ff];
      end
      if (cmd.execute) begin
         rsp_data_ff <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (rx_we) begin
         rx_store_ff[rx_wr_ff] <= line_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (tx_we) begin
         tx_store_ff[tx_fill_ff] <= tx_wdata;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
